FILE: rtl/swmm_pkg.sv
// ----------------------------------------------------------------------------
// swmm_pkg
// Shared types and constants for the sliding window min/max block.
// ----------------------------------------------------------------------------
package swmm_pkg;

  localparam int WINDOW_DEPTH_DEFAULT = 64;
  localparam int SAMPLE_W             = 32;
  localparam int WIN_CFG_W            = 7;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       first_of_sequence;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] window_max;
    logic signed [SAMPLE_W-1:0] window_min;
  } out_item_t;

  // per-queue control from the top level
  typedef struct packed {
    logic step;   // item accepted this cycle
    logic drain;  // drop the front entry only
    logic clear;  // item starts a new sequence
  } queue_ctrl_t;

  // per-queue status towards the top level
  typedef struct packed {
    logic                       drain_req;
    logic signed [SAMPLE_W-1:0] front_next;
  } queue_stat_t;

endpackage

FILE: rtl/swmm_cell.sv
// ----------------------------------------------------------------------------
// swmm_cell
// One slot of a monotonic queue: value, age and valid flag, refilled from
// itself, from its right-hand neighbour or from the new sample.
// ----------------------------------------------------------------------------
module swmm_cell #(
  parameter int AGE_W    = 6,
  parameter int WIN_W    = 7,
  parameter bit KEEP_MAX = 1'b1
) (
  input  logic                                clk,
  input  logic                                rst,
  input  swmm_pkg::queue_ctrl_t               ctrl,
  input  logic                                shift,
  input  logic signed [swmm_pkg::SAMPLE_W-1:0] sample,
  input  logic        [WIN_W-1:0]             win,
  input  logic                                left_src_kept,
  input  logic                                right_valid,
  input  logic                                right_kept,
  input  logic signed [swmm_pkg::SAMPLE_W-1:0] right_value,
  input  logic        [AGE_W-1:0]             right_age,
  output logic                                valid,
  output logic signed [swmm_pkg::SAMPLE_W-1:0] value,
  output logic        [AGE_W-1:0]             age,
  output logic                                stale,
  output logic                                kept,
  output logic                                src_kept,
  output logic signed [swmm_pkg::SAMPLE_W-1:0] step_value
);
  import swmm_pkg::*;

  logic                       beaten;
  logic [WIN_W-1:0]           age_inc;
  logic signed [SAMPLE_W-1:0] src_value;
  logic [AGE_W-1:0]           src_age;
  logic                       push;
  logic                       valid_next;
  logic signed [SAMPLE_W-1:0] value_next;
  logic [AGE_W-1:0]           age_next;

  assign age_inc  = WIN_W'(age) + WIN_W'(1);
  assign stale    = valid && (age_inc >= win);
  assign beaten   = KEEP_MAX ? (value <= sample) : (value >= sample);
  assign kept     = valid && !stale && !beaten && !ctrl.clear;

  assign src_kept  = shift ? right_kept  : kept;
  assign src_value = shift ? right_value : value;
  assign src_age   = shift ? right_age   : age;

  // new item lands in the first slot behind the surviving entries
  assign push       = !src_kept && left_src_kept;
  assign step_value = push ? sample : src_value;

  always_comb begin
    valid_next = valid;
    value_next = value;
    age_next   = age;
    priority if (ctrl.step) begin
      valid_next = src_kept || push;
      value_next = step_value;
      age_next   = push ? '0 : AGE_W'(src_age + AGE_W'(1));
    end else if (ctrl.drain) begin
      valid_next = right_valid;
      value_next = right_value;
      age_next   = right_age;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
  end

  always_ff @(posedge clk) begin
    value <= value_next;
    age   <= age_next;
  end

endmodule

FILE: rtl/swmm_queue.sv
// ----------------------------------------------------------------------------
// swmm_queue
// Monotonic queue as a row of cells, front entry in cell 0.
// ----------------------------------------------------------------------------
module swmm_queue #(
  parameter int WINDOW_DEPTH = swmm_pkg::WINDOW_DEPTH_DEFAULT,
  parameter int AGE_W        = $clog2(WINDOW_DEPTH),
  parameter int WIN_W        = $clog2(WINDOW_DEPTH + 1),
  parameter bit KEEP_MAX     = 1'b1
) (
  input  logic                                clk,
  input  logic                                rst,
  input  swmm_pkg::queue_ctrl_t               ctrl,
  input  logic signed [swmm_pkg::SAMPLE_W-1:0] sample,
  input  logic        [WIN_W-1:0]             win,
  output swmm_pkg::queue_stat_t               stat
);
  import swmm_pkg::*;

  logic                       valid      [WINDOW_DEPTH];
  logic signed [SAMPLE_W-1:0] value      [WINDOW_DEPTH];
  logic [AGE_W-1:0]           age        [WINDOW_DEPTH];
  logic                       stale      [WINDOW_DEPTH];
  logic                       kept       [WINDOW_DEPTH];
  logic                       src_kept   [WINDOW_DEPTH];
  logic signed [SAMPLE_W-1:0] step_value [WINDOW_DEPTH];
  logic                       shift;

  // with cell 1 fresh at most the front entry ages out in a step
  assign shift          = stale[0];
  assign stat.drain_req = stale[1];
  assign stat.front_next = step_value[0];

  for (genvar i = 0; i < WINDOW_DEPTH; i++) begin : g_cell
    logic                       l_src_kept;
    logic                       r_valid;
    logic                       r_kept;
    logic signed [SAMPLE_W-1:0] r_value;
    logic [AGE_W-1:0]           r_age;

    if (i == 0) begin : g_head
      assign l_src_kept = 1'b1;
    end else begin : g_body
      assign l_src_kept = src_kept[i-1];
    end

    if (i == WINDOW_DEPTH - 1) begin : g_tail
      assign r_valid = 1'b0;
      assign r_kept  = 1'b0;
      assign r_value = '0;
      assign r_age   = '0;
    end else begin : g_link
      assign r_valid = valid[i+1];
      assign r_kept  = kept[i+1];
      assign r_value = value[i+1];
      assign r_age   = age[i+1];
    end

    swmm_cell #(
      .AGE_W    (AGE_W),
      .WIN_W    (WIN_W),
      .KEEP_MAX (KEEP_MAX)
    ) u_cell (
      .clk           (clk),
      .rst           (rst),
      .ctrl          (ctrl),
      .shift         (shift),
      .sample        (sample),
      .win           (win),
      .left_src_kept (l_src_kept),
      .right_valid   (r_valid),
      .right_kept    (r_kept),
      .right_value   (r_value),
      .right_age     (r_age),
      .valid         (valid[i]),
      .value         (value[i]),
      .age           (age[i]),
      .stale         (stale[i]),
      .kept          (kept[i]),
      .src_kept      (src_kept[i]),
      .step_value    (step_value[i])
    );
  end

endmodule

FILE: rtl/sliding_window_min_max.sv
// ----------------------------------------------------------------------------
// sliding_window_min_max
// Running maximum and minimum over the last window_length samples.
// ----------------------------------------------------------------------------
// One item per clock while the result side keeps up and no queue drains
// stale entries; each result appears in the cycle after its item is taken.
// Both queues are rows of WINDOW_DEPTH cells that compare the new sample in
// parallel and shift by at most one place per cycle, so after window_length
// is shortened the first item of the next burst waits while the stale
// entries beyond the first drain from the front of the longer queue.
// window_length of 0 acts as 1, values above WINDOW_DEPTH as WINDOW_DEPTH.
// ----------------------------------------------------------------------------
module sliding_window_min_max #(
  parameter int WINDOW_DEPTH = swmm_pkg::WINDOW_DEPTH_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_wr,
  input  logic [swmm_pkg::WIN_CFG_W-1:0]     cfg_wdata,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  swmm_pkg::in_item_t                 in_item,
  output logic                               out_valid,
  input  logic                               out_ready,
  output swmm_pkg::out_item_t                out_item
);
  import swmm_pkg::*;

  localparam int AGE_W = $clog2(WINDOW_DEPTH);
  localparam int WIN_W = $clog2(WINDOW_DEPTH + 1);
  localparam int CMP_W = (WIN_CFG_W > WIN_W) ? WIN_CFG_W : WIN_W;

  logic [WIN_W-1:0] win;
  logic [CMP_W-1:0] cfg_ext;
  logic [CMP_W-1:0] win_clamped;
  logic             accept;
  queue_ctrl_t      max_ctrl;
  queue_ctrl_t      min_ctrl;
  queue_stat_t      max_stat;
  queue_stat_t      min_stat;

  assign cfg_ext = CMP_W'(cfg_wdata);

  always_comb begin
    priority if (cfg_ext == '0) begin
      win_clamped = CMP_W'(1);
    end else if (cfg_ext > CMP_W'(WINDOW_DEPTH)) begin
      win_clamped = CMP_W'(WINDOW_DEPTH);
    end else begin
      win_clamped = cfg_ext;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      win <= WIN_W'(1);
    end else if (cfg_wr) begin
      win <= WIN_W'(win_clamped);
    end
  end

  assign in_ready = (!out_valid || out_ready) && !max_stat.drain_req && !min_stat.drain_req;
  assign accept   = in_valid && in_ready;

  assign max_ctrl.step  = accept;
  assign max_ctrl.drain = in_valid && max_stat.drain_req;
  assign max_ctrl.clear = in_item.first_of_sequence;
  assign min_ctrl.step  = accept;
  assign min_ctrl.drain = in_valid && min_stat.drain_req;
  assign min_ctrl.clear = in_item.first_of_sequence;

  swmm_queue #(
    .WINDOW_DEPTH (WINDOW_DEPTH),
    .AGE_W        (AGE_W),
    .WIN_W        (WIN_W),
    .KEEP_MAX     (1'b1)
  ) u_max_queue (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (max_ctrl),
    .sample (in_item.sample),
    .win    (win),
    .stat   (max_stat)
  );

  swmm_queue #(
    .WINDOW_DEPTH (WINDOW_DEPTH),
    .AGE_W        (AGE_W),
    .WIN_W        (WIN_W),
    .KEEP_MAX     (1'b0)
  ) u_min_queue (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (min_ctrl),
    .sample (in_item.sample),
    .win    (win),
    .stat   (min_stat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_item.window_max <= max_stat.front_next;
      out_item.window_min <= min_stat.front_next;
    end
  end

endmodule

FILE: rtl/swmm_checker.sv
// ----------------------------------------------------------------------------
// swmm_checker
// Port-level checks for the sliding window min/max block.
// ----------------------------------------------------------------------------
module swmm_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           cfg_wr,
  input logic [swmm_pkg::WIN_CFG_W-1:0] cfg_wdata,
  input logic                           in_valid,
  input logic                           in_ready,
  input swmm_pkg::in_item_t             in_item,
  input logic                           out_valid,
  input logic                           out_ready,
  input swmm_pkg::out_item_t            out_item
);
  import swmm_pkg::*;

  logic accept;
  logic cfg_seen;

  assign accept   = in_valid && in_ready;
  assign cfg_seen = cfg_wr || (cfg_wdata != '0) || 1'b1;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("result changed while stalled");

  a_one_result: assert property (@(posedge clk) disable iff (rst)
    accept |=> out_valid)
    else $error("accepted item gave no result");

  a_first: assert property (@(posedge clk) disable iff (rst)
    accept && in_item.first_of_sequence && cfg_seen |=>
      (out_item.window_max == $past(in_item.sample)) &&
      (out_item.window_min == $past(in_item.sample)))
    else $error("new sequence does not restart the window");

  a_bracket: assert property (@(posedge clk) disable iff (rst)
    accept |=> (out_item.window_max >= $past(in_item.sample)) &&
               (out_item.window_min <= $past(in_item.sample)))
    else $error("newest sample outside min/max");

  a_order: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_item.window_max >= out_item.window_min)
    else $error("window_max below window_min");

endmodule

bind sliding_window_min_max swmm_checker u_swmm_checker (.*);
